[rtl/core/tlm_pkg.sv]
// Shared types and constants for the two-list sorted merge core.
`default_nettype none

package tlm_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int SUM_W      = CNT_W + 1;

   typedef enum logic [1:0] {
      CMD_PUSH_A = 2'd0,
      CMD_PUSH_B = 2'd1,
      CMD_MERGE  = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_MERGE = 1'b1
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     empty;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/tlm_ram.sv]
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module tlm_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[rtl/core/tlm_ctrl.sv]
// Command decode, list fill counts and the merge walk over the two list memories.
`default_nettype none

module tlm_ctrl import tlm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [1:0]               req_command,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic signed [DATA_W-1:0] ram_a_rdata,
   input  wire logic signed [DATA_W-1:0] ram_b_rdata,
   output logic                          busy,
   output ram_req_type                   ram_a_req,
   output ram_req_type                   ram_b_req,
   output result_type                    result
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]  cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]  ia_ff, ia_in;
   logic [CNT_W-1:0]  ib_ff, ib_in;
   logic              accept;
   logic              a_rem;
   logic              b_rem;
   logic              take_a;
   logic              is_last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ia_ff    <= '0;
         ib_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ia_ff    <= ia_in;
         ib_ff    <= ib_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;

      ram_a_req.we    = 1'b0;
      ram_a_req.waddr = cnt_a_ff[ADDR_W-1:0];
      ram_a_req.wdata = req_value;
      ram_b_req.we    = 1'b0;
      ram_b_req.waddr = cnt_b_ff[ADDR_W-1:0];
      ram_b_req.wdata = req_value;

      result = '0;

      a_rem   = (ia_ff < cnt_a_ff);
      b_rem   = (ib_ff < cnt_b_ff);
      take_a  = a_rem && (!b_rem || (ram_a_rdata < ram_b_rdata));
      is_last = ((SUM_W'(ia_ff) + SUM_W'(ib_ff) + SUM_W'(1)) ==
                 (SUM_W'(cnt_a_ff) + SUM_W'(cnt_b_ff)));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_PUSH_A: begin
                     if (cnt_a_ff < CNT_W'(LIST_DEPTH)) begin
                        ram_a_req.we = 1'b1;
                        cnt_a_in     = cnt_a_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUSH_B: begin
                     if (cnt_b_ff < CNT_W'(LIST_DEPTH)) begin
                        ram_b_req.we = 1'b1;
                        cnt_b_in     = cnt_b_ff + CNT_W'(1);
                     end
                  end
                  CMD_MERGE: begin
                     if ((cnt_a_ff == '0) && (cnt_b_ff == '0)) begin
                        result.valid = 1'b1;
                        result.last  = 1'b1;
                        result.empty = 1'b1;
                     end else begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            result.valid = 1'b1;
            result.last  = is_last;
            if (take_a) begin
               result.value = ram_a_rdata;
               ia_in        = ia_ff + CNT_W'(1);
            end else begin
               result.value = ram_b_rdata;
               ib_in        = ib_ff + CNT_W'(1);
            end
            if (is_last) begin
               state_in = ST_IDLE;
               cnt_a_in = '0;
               cnt_b_in = '0;
               ia_in    = '0;
               ib_in    = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The read address follows the next head index, so the head entry is
      // waiting in the read register on the following cycle.
      ram_a_req.raddr = ia_in[ADDR_W-1:0];
      ram_b_req.raddr = ib_in[ADDR_W-1:0];
   end

   a_merge_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ((cnt_a_ff != '0) || (cnt_b_ff != '0)))
      else $error("merge running with both lists empty");

   a_index_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ((ia_ff <= cnt_a_ff) && (ib_ff <= cnt_b_ff)
                                  && (a_rem || b_rem)))
      else $error("merge index ran past its list");

   a_last_ends_merge: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MERGE) && is_last) |=>
         ((state_ff == ST_IDLE) && (cnt_a_ff == '0) && (cnt_b_ff == '0)))
      else $error("final result did not clear the lists");

   a_no_write_in_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (!ram_a_req.we && !ram_b_req.we && result.valid))
      else $error("write or missing result during merge");

endmodule

`default_nettype wire

[rtl/core/two_list_sorted_merge_core.sv]
// Top level of the two-list sorted merge core: list memories, control and result register.
// A push is taken while idle and gives no result. A merge gives its first result once the
// start beat has passed the state register and the result register, then one result per
// cycle; an empty merge gives its single result in the cycle after the start beat.
// Throughput: pushes one per cycle while busy is low; a merge keeps busy high until its
// last value has been chosen.
// Reset is synchronous and active high: both lists are emptied and no result is pending.
`default_nettype none

module two_list_sorted_merge_core import tlm_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_command,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_merged_value,
   output logic                          rsp_last,
   output logic                          rsp_empty_res
);

   ram_req_type              ram_a_req;
   ram_req_type              ram_b_req;
   logic signed [DATA_W-1:0] ram_a_rdata;
   logic signed [DATA_W-1:0] ram_b_rdata;
   result_type               result;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     rsp_empty_ff;

   // List A holds the values pushed with the list A command, in arrival order.
   tlm_ram #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (DATA_W)
   ) u_ram_a (
      .clock (clock),
      .we    (ram_a_req.we),
      .waddr (ram_a_req.waddr),
      .wdata (ram_a_req.wdata),
      .raddr (ram_a_req.raddr),
      .rdata (ram_a_rdata)
   );

   // List B mirrors list A for the second command.
   tlm_ram #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (DATA_W)
   ) u_ram_b (
      .clock (clock),
      .we    (ram_b_req.we),
      .waddr (ram_b_req.waddr),
      .wdata (ram_b_req.wdata),
      .raddr (ram_b_req.raddr),
      .rdata (ram_b_rdata)
   );

   // The control block decodes each beat, keeps the fill counts and walks the
   // two list heads during a merge, choosing one value per cycle.
   tlm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .req_value   (req_value),
      .ram_a_rdata (ram_a_rdata),
      .ram_b_rdata (ram_b_rdata),
      .busy        (busy),
      .ram_a_req   (ram_a_req),
      .ram_b_req   (ram_b_req),
      .result      (result)
   );

   // The result register: each chosen value is shown for exactly one cycle.
   // Only the strobe needs a reset; the payload follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= result.value;
      rsp_last_ff  <= result.last;
      rsp_empty_ff <= result.empty;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_empty_res    = rsp_empty_ff;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the two-list sorted merge core.
`timescale 1ns / 1ps

module testbench;
   import tlm_pkg::*;

   // Command code that the core must ignore; the package names only the three it acts on.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 130;
   localparam int MAX_REPORTS   = 10;
   // A merge of two full lists is 64 beats; a settling wait is allowed once the last expected
   // beat has been seen.
   localparam int SETTLE_CYCLES = 8;
   // The limit lies far above the length of the slowest correct run.
   localparam int CYCLE_LIMIT   = 400000;

   // One beat of merged output as the core should present it.
   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     empty;
   } merged_word_type;

   // One row of the directed table. Where typed is set, the wanted beat is written out
   // by hand and the predictor only keeps its copy of the lists in step.
   typedef struct packed {
      logic [1:0]        command;
      logic [DATA_W-1:0] value;
      logic              typed;
      logic [DATA_W-1:0] want_value;
      logic              want_last;
      logic              want_empty;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_command;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_merged_value;
   logic                     rsp_last;
   logic                     rsp_empty_res;

   // The predictor's own copy of both lists, and the beats still owed by the core.
   logic signed [DATA_W-1:0] held_a[$];
   logic signed [DATA_W-1:0] held_b[$];
   merged_word_type          expected_words[$];

   stim_row_type directed_rows [0:DIRECTED_ROWS-1];

   int mismatches     = 0;
   int beats_checked  = 0;
   int pushes_taken   = 0;
   int pushes_dropped = 0;
   int merges_taken   = 0;
   int unused_seen    = 0;
   int cycle_count    = 0;
   int sender_gap_pct = 6;

   two_list_sorted_merge_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res)
   );

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still expected",
                  cycle_count, expected_words.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Predictor. It is called at the edge where the core accepts a beat. A push appends to
   // its list unless that list is already full, in which case it is dropped. A merge walks
   // both lists from the front, always taking the smaller head and, on a tie, the head of
   // list B; once one list runs out the rest of the other follows in stored order, with no
   // comparison made against the empty list. Both lists empty gives a single beat flagged
   // empty with a zero value. The unused command code changes nothing.
   task automatic model_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                                input bit record, output bit effective);
      int              ia;
      int              ib;
      int              total;
      bit              take_a;
      merged_word_type w;
      effective = 1'b0;
      case (cmd)
         CMD_PUSH_A: begin
            if (held_a.size() < LIST_DEPTH) begin
               held_a.push_back(val);
               pushes_taken++;
               effective = 1'b1;
            end else begin
               pushes_dropped++;
            end
         end
         CMD_PUSH_B: begin
            if (held_b.size() < LIST_DEPTH) begin
               held_b.push_back(val);
               pushes_taken++;
               effective = 1'b1;
            end else begin
               pushes_dropped++;
            end
         end
         CMD_MERGE: begin
            effective = 1'b1;
            merges_taken++;
            total = held_a.size() + held_b.size();
            if (total == 0) begin
               w.value = '0;
               w.last  = 1'b1;
               w.empty = 1'b1;
               if (record) expected_words.push_back(w);
            end else begin
               ia = 0;
               ib = 0;
               while (ia + ib < total) begin
                  if (ia >= held_a.size())
                     take_a = 1'b0;
                  else if (ib >= held_b.size())
                     take_a = 1'b1;
                  else
                     take_a = held_a[ia] < held_b[ib];
                  if (take_a) begin
                     w.value = held_a[ia];
                     ia++;
                  end else begin
                     w.value = held_b[ib];
                     ib++;
                  end
                  w.last  = (ia + ib == total);
                  w.empty = 1'b0;
                  if (record) expected_words.push_back(w);
               end
            end
            held_a.delete();
            held_b.delete();
         end
         default: begin
            unused_seen++;
         end
      endcase
   endtask

   // Presents one command beat and holds it until the core takes it. Before the beat the
   // sender may pause, as often as the current phase asks. The start line is lowered only
   // for such a pause or a drain wait, so back-to-back beats keep it high throughout.
   task automatic issue_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                                input bit record, output bit effective);
      if ($urandom_range(0, 99) < sender_gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      do @(posedge clock); while (busy);
      model_command(cmd, val, record, effective);
   endtask

   // Holds the sender off until every beat owed by the core has arrived.
   task automatic wait_for_merge_drain();
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Values near zero, so that ties between the lists are common, together with both
   // extremes and, most often, values spread over the whole range.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int near_zero;
      case ($urandom_range(0, 9))
         0: pick_value = MOST_NEGATIVE;
         1: pick_value = MOST_POSITIVE;
         2, 3, 4: begin
            near_zero  = $urandom_range(0, 8);
            pick_value = near_zero - 4;
         end
         default: pick_value = $urandom;
      endcase
   endfunction

   // Result checker. The core cannot be held off, so every strobed beat is taken at the
   // rising edge that ends its cycle and matched against the oldest expectation.
   always @(posedge clock) begin : check_merged_beats
      merged_word_type want;
      if (!reset && rsp_valid) begin
         beats_checked++;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected beat: value %0d last %0b empty %0b",
                        $realtime, rsp_merged_value, rsp_last, rsp_empty_res);
         end else begin
            want = expected_words.pop_front();
            if (rsp_merged_value !== want.value || rsp_last !== want.last ||
                rsp_empty_res !== want.empty) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] beat mismatch: expected value %0d last %0b empty %0b, %s",
                           $realtime, want.value, want.last, want.empty,
                           $sformatf("got value %0d last %0b empty %0b",
                                     rsp_merged_value, rsp_last, rsp_empty_res));
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type             row;
      merged_word_type          typed_word;
      bit                       effective;
      bit                       sorted_seq;
      int                       counted;
      int                       seq_idx;
      int                       phase;
      int                       next_phase;
      int                       kind;
      int                       na;
      int                       nb;
      int                       ia;
      int                       ib;
      int                       pos;
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] tmp[$];
      logic signed [DATA_W-1:0] seq_a[$];
      logic signed [DATA_W-1:0] seq_b[$];

      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_PUSH_A;
      req_value   = '0;

      // Directed table. Merges whose outcome is plain from the lists are typed in: the
      // first merge after reset, a merge where the unused command was the only beat since
      // the last one, and single extreme values. The rest go through the predictor: a tie
      // across the lists, list B left empty, lists pushed out of order, and extremes on
      // both sides.
      directed_rows[0]  = '{CMD_MERGE,  '0,            1'b1, '0,            1'b1, 1'b1};
      directed_rows[1]  = '{CMD_UNUSED, '1,            1'b0, '0,            1'b0, 1'b0};
      directed_rows[2]  = '{CMD_MERGE,  '1,            1'b1, '0,            1'b1, 1'b1};
      directed_rows[3]  = '{CMD_PUSH_A, MOST_NEGATIVE, 1'b0, '0,            1'b0, 1'b0};
      directed_rows[4]  = '{CMD_MERGE,  '0,            1'b1, MOST_NEGATIVE, 1'b1, 1'b0};
      directed_rows[5]  = '{CMD_PUSH_B, MOST_POSITIVE, 1'b0, '0,            1'b0, 1'b0};
      directed_rows[6]  = '{CMD_MERGE,  '0,            1'b1, MOST_POSITIVE, 1'b1, 1'b0};
      directed_rows[7]  = '{CMD_PUSH_A, -32'sd5,       1'b0, '0,            1'b0, 1'b0};
      directed_rows[8]  = '{CMD_PUSH_B, -32'sd5,       1'b0, '0,            1'b0, 1'b0};
      directed_rows[9]  = '{CMD_PUSH_A, 32'sd0,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[10] = '{CMD_PUSH_B, 32'sd0,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[11] = '{CMD_PUSH_B, MOST_POSITIVE, 1'b0, '0,            1'b0, 1'b0};
      directed_rows[12] = '{CMD_MERGE,  '0,            1'b0, '0,            1'b0, 1'b0};
      directed_rows[13] = '{CMD_PUSH_A, 32'sd1,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[14] = '{CMD_PUSH_A, 32'sd2,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[15] = '{CMD_PUSH_A, 32'sd3,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[16] = '{CMD_MERGE,  '0,            1'b0, '0,            1'b0, 1'b0};
      directed_rows[17] = '{CMD_PUSH_A, 32'sd10,       1'b0, '0,            1'b0, 1'b0};
      directed_rows[18] = '{CMD_PUSH_A, -32'sd10,      1'b0, '0,            1'b0, 1'b0};
      directed_rows[19] = '{CMD_PUSH_B, 32'sd0,        1'b0, '0,            1'b0, 1'b0};
      directed_rows[20] = '{CMD_MERGE,  '0,            1'b0, '0,            1'b0, 1'b0};
      directed_rows[21] = '{CMD_PUSH_B, MOST_NEGATIVE, 1'b0, '0,            1'b0, 1'b0};
      directed_rows[22] = '{CMD_PUSH_A, MOST_POSITIVE, 1'b0, '0,            1'b0, 1'b0};
      directed_rows[23] = '{CMD_MERGE,  '0,            1'b0, '0,            1'b0, 1'b0};

      // Synchronous reset, held while the clock runs and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         issue_command(row.command, row.value, !row.typed, effective);
         if (row.typed && row.command == CMD_MERGE) begin
            typed_word.value = row.want_value;
            typed_word.last  = row.want_last;
            typed_word.empty = row.want_empty;
            expected_words.push_back(typed_word);
         end
      end

      // Random part, built from load-and-merge sequences. Most lists are short and pushed
      // in ascending order, with the two lists interleaved at random; some sequences push
      // in no order at all, the unused command is scattered through, and a merge is now
      // and then followed straight away by a merge of two empty lists. The third and sixth
      // sequences overfill a list so that pushes to a full list are dropped, the sixth
      // filling both lists for the longest merge the core can give.
      // The run passes through three phases of sender pauses, and at each change of phase
      // the sender waits until the core has delivered everything it owes.
      counted = 0;
      seq_idx = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         next_phase = (counted * 3) / RANDOM_ITEMS;
         if (next_phase != phase) begin
            wait_for_merge_drain();
            phase          = next_phase;
            sender_gap_pct = (phase == 1) ? 49 : 0;
         end

         kind       = $urandom_range(0, 99);
         sorted_seq = (kind >= 12);
         if (seq_idx == 2) begin
            na = LIST_DEPTH + $urandom_range(1, 3);
            nb = $urandom_range(0, 4);
         end else if (seq_idx == 5) begin
            na = LIST_DEPTH + $urandom_range(1, 2);
            nb = LIST_DEPTH + $urandom_range(1, 2);
         end else if (kind < 10) begin
            na = $urandom_range(0, 16);
            nb = $urandom_range(0, 16);
         end else begin
            na = $urandom_range(0, 6);
            nb = $urandom_range(0, 6);
         end

         // Build both lists, keeping each one ascending where the sequence is well formed.
         for (int l = 0; l < 2; l++) begin
            tmp.delete();
            for (int n = 0; n < ((l == 0) ? na : nb); n++) begin
               v = pick_value();
               pos = 0;
               if (sorted_seq)
                  while (pos < tmp.size() && tmp[pos] <= v) pos++;
               else
                  pos = tmp.size();
               tmp.insert(pos, v);
            end
            if (l == 0)
               seq_a = tmp;
            else
               seq_b = tmp;
         end

         ia = 0;
         ib = 0;
         while (ia < na || ib < nb) begin
            if ($urandom_range(0, 99) < 4)
               issue_command(CMD_UNUSED, $urandom, 1'b1, effective);
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
               issue_command(CMD_PUSH_A, seq_a[ia], 1'b1, effective);
               ia++;
            end else begin
               issue_command(CMD_PUSH_B, seq_b[ib], 1'b1, effective);
               ib++;
            end
            if (effective) counted++;
         end

         issue_command(CMD_MERGE, $urandom, 1'b1, effective);
         counted++;
         if ($urandom_range(0, 99) < 10) begin
            issue_command(CMD_MERGE, $urandom, 1'b1, effective);
            counted++;
         end
         seq_idx++;
      end

      // Let everything owed arrive, then keep watching through the settling wait for any stray beat.
      wait_for_merge_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d accepted pushes, %0d dropped pushes to a full list, %0d merges",
               pushes_taken, pushes_dropped, merges_taken);
      $display("and %0d unused commands; %0d merged beats checked, %0d mismatches.",
               unused_seen, beats_checked, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[two_list_sorted_merge_core.f]
rtl/core/tlm_pkg.sv
rtl/core/tlm_ram.sv
rtl/core/tlm_ctrl.sv
rtl/core/two_list_sorted_merge_core.sv
tb/sv/testbench.sv
